@@ src/oaht_pkg.sv @@
// Shared types and constants of the open-addressing hash table engine.
package oaht_pkg;

  localparam int unsigned MAX_SLOTS = 1024;
  localparam int unsigned SLOT_W = $clog2(MAX_SLOTS);
  localparam int unsigned CAP_W = SLOT_W + 1;
  localparam int unsigned KEY_BITS = 64;
  localparam int unsigned HOME_W = 10;
  localparam int unsigned CFG_W = 11;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_SIZE = 1'd0,
    REG_PROBE_KIND = 1'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_GET    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    PROBE_LINEAR = 2'd0,
    PROBE_QUAD   = 2'd1,
    PROBE_DOUBLE = 2'd2,
    PROBE_UNUSED = 2'd3
  } probe_e;

  typedef enum logic [1:0] {
    RES_OK       = 2'd0,
    RES_NOTFOUND = 2'd1,
    RES_FULL     = 2'd2
  } res_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_e;

endpackage

@@ src/open_address_hash_table.sv @@
// Top level of the open-addressing hash table engine with tombstones.
// After reset, and for every clear transaction, the engine sweeps every entry of the
// slot-state memory before it answers; during the reset sweep it takes no transaction.
// An insert that finds the occupancy at cap - 1 is answered as full without probing.
// Any other request reduces the home slot with a shift-subtract remainder unit, then
// probes slot by slot (a memory read step, then a compare and step), then writes back
// and presents the result once the output is free, with at most cap probes (table_size
// clamped to 2..MAX_SLOTS). A single adder and compare advances the probe index for all three probe kinds.
module open_address_hash_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [oaht_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [oaht_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    in_req_type_i,
  input  logic [63:0]                   in_key_i,
  input  logic [9:0]                    in_home_index_i,
  input  logic signed [31:0]            in_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    out_status_o,
  output logic signed [31:0]            out_value_out_o,
  output logic [9:0]                    out_slot_index_o
);
  import oaht_pkg::*;

  logic [CFG_W-1:0] table_size_q;
  logic [1:0]       probe_kind_q;
  state_e           state_q, state_d;
  logic [CAP_W-1:0] occ_q, occ_d;
  logic [SLOT_W-1:0] clr_q, clr_d;
  logic             clr_reply_q, clr_reply_d;
  logic [1:0]       req_q, req_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [31:0]      val_q, val_d;
  logic [HOME_W-1:0] hsh_q, hsh_d;
  logic [3:0]       bit_q, bit_d;
  logic [CAP_W-1:0] rem_q, rem_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [SLOT_W-1:0] inc_q, inc_d;
  logic [CAP_W-1:0] off_q, off_d;
  logic             found_q, found_d;
  logic             tomb_ok_q, tomb_ok_d;
  logic [SLOT_W-1:0] tomb_q, tomb_d;
  logic             empty_q, empty_d;
  logic             full_q, full_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_status_q, out_status_d;
  logic [31:0]      out_val_q, out_val_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;

  logic [1:0]          st_mem [MAX_SLOTS];
  logic [KEY_BITS-1:0] key_mem [MAX_SLOTS];
  logic [31:0]         val_mem [MAX_SLOTS];
  logic [1:0]          st_rd_q;
  logic [KEY_BITS-1:0] key_rd_q;
  logic [31:0]         val_rd_q;

  logic             rd_en;
  logic             st_we, kv_we, v_we;
  logic [SLOT_W-1:0] wr_addr;
  logic [1:0]       st_wd;
  logic [CAP_W-1:0] cap;
  logic [CAP_W-1:0] sum;
  logic [CAP_W-1:0] sum_mod;
  logic [CAP_W-1:0] inc2;
  logic [CAP_W-1:0] shifted;
  logic [CAP_W-1:0] home_step;
  logic             out_free;

  always_comb begin
    cap = table_size_q;
    if (table_size_q < CAP_W'(2)) begin
      cap = CAP_W'(2);
    end else if (table_size_q > CAP_W'(MAX_SLOTS)) begin
      cap = CAP_W'(MAX_SLOTS);
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign sum = {1'b0, idx_q} + {1'b0, inc_q};
  assign sum_mod = (sum >= cap) ? sum - cap : sum;
  assign inc2 = {1'b0, inc_q} + CAP_W'(2);
  assign shifted = {rem_q[CAP_W-2:0], hsh_q[HOME_W-1]};
  assign home_step = (rem_q == cap - CAP_W'(1)) ? CAP_W'(1) : rem_q + CAP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= CFG_W'(1021);
      probe_kind_q <= PROBE_LINEAR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TABLE_SIZE: table_size_q <= cfg_data_i;
        REG_PROBE_KIND: probe_kind_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      occ_q       <= '0;
      clr_q       <= '0;
      clr_reply_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      clr_q       <= clr_d;
      clr_reply_q <= clr_reply_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    key_q        <= key_d;
    val_q        <= val_d;
    hsh_q        <= hsh_d;
    bit_q        <= bit_d;
    rem_q        <= rem_d;
    idx_q        <= idx_d;
    inc_q        <= inc_d;
    off_q        <= off_d;
    found_q      <= found_d;
    tomb_ok_q    <= tomb_ok_d;
    tomb_q       <= tomb_d;
    empty_q      <= empty_d;
    full_q       <= full_d;
    out_status_q <= out_status_d;
    out_val_q    <= out_val_d;
    out_slot_q   <= out_slot_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[wr_addr] <= st_wd;
    end
    if (kv_we) begin
      key_mem[wr_addr] <= key_q;
    end
    if (v_we) begin
      val_mem[wr_addr] <= val_q;
    end
    if (rd_en) begin
      st_rd_q  <= st_mem[idx_q];
      key_rd_q <= key_mem[idx_q];
      val_rd_q <= val_mem[idx_q];
    end
  end

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    clr_d        = clr_q;
    clr_reply_d  = clr_reply_q;
    req_d        = req_q;
    key_d        = key_q;
    val_d        = val_q;
    hsh_d        = hsh_q;
    bit_d        = bit_q;
    rem_d        = rem_q;
    idx_d        = idx_q;
    inc_d        = inc_q;
    off_d        = off_q;
    found_d      = found_q;
    tomb_ok_d    = tomb_ok_q;
    tomb_d       = tomb_q;
    empty_d      = empty_q;
    full_d       = full_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_val_d    = out_val_q;
    out_slot_d   = out_slot_q;
    in_stall_o   = 1'b1;
    rd_en        = 1'b0;
    st_we        = 1'b0;
    kv_we        = 1'b0;
    v_we         = 1'b0;
    wr_addr      = idx_q;
    st_wd        = SLOT_EMPTY;

    case (state_q)
      ST_CLEAR: begin
        st_we   = 1'b1;
        wr_addr = clr_q;
        st_wd   = SLOT_EMPTY;
        clr_d   = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(MAX_SLOTS - 1)) begin
          occ_d = '0;
          if (clr_reply_q) begin
            full_d  = 1'b0;
            state_d = ST_FINISH;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          req_d     = in_req_type_i;
          key_d     = in_key_i;
          val_d     = in_value_i;
          hsh_d     = in_home_index_i;
          bit_d     = '0;
          rem_d     = '0;
          found_d   = 1'b0;
          tomb_ok_d = 1'b0;
          empty_d   = 1'b0;
          full_d    = 1'b0;
          if (in_req_type_i == REQ_CLEAR) begin
            clr_d       = '0;
            clr_reply_d = 1'b1;
            state_d     = ST_CLEAR;
          end else if (in_req_type_i == REQ_INSERT && occ_q >= cap - CAP_W'(1)) begin
            full_d  = 1'b1;
            state_d = ST_FINISH;
          end else begin
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        rem_d = (shifted >= cap) ? shifted - cap : shifted;
        hsh_d = {hsh_q[HOME_W-2:0], 1'b0};
        bit_d = bit_q + 4'd1;
        if (bit_q == 4'(HOME_W)) begin
          rem_d = rem_q;
          idx_d = rem_q[SLOT_W-1:0];
          off_d = '0;
          case (probe_kind_q)
            PROBE_DOUBLE: inc_d = home_step[SLOT_W-1:0];
            default:      inc_d = SLOT_W'(1);
          endcase
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (st_rd_q == SLOT_EMPTY) begin
          empty_d = 1'b1;
          state_d = ST_FINISH;
        end else if (st_rd_q == SLOT_USED && key_rd_q == key_q) begin
          found_d = 1'b1;
          state_d = ST_FINISH;
        end else begin
          if (st_rd_q == SLOT_TOMB && !tomb_ok_q) begin
            tomb_ok_d = 1'b1;
            tomb_d    = idx_q;
          end
          off_d = off_q + CAP_W'(1);
          if (off_q + CAP_W'(1) == cap) begin
            state_d = ST_FINISH;
          end else begin
            idx_d = sum_mod[SLOT_W-1:0];
            if (probe_kind_q == PROBE_QUAD) begin
              inc_d = (inc2 >= cap) ? SLOT_W'(inc2 - cap) : inc2[SLOT_W-1:0];
            end
            state_d = ST_READ;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_val_d    = '0;
          out_slot_d   = '0;
          out_status_d = RES_NOTFOUND;
          state_d      = ST_IDLE;
          if (clr_reply_q) begin
            clr_reply_d  = 1'b0;
            out_status_d = RES_OK;
          end else if (full_q) begin
            out_status_d = RES_FULL;
          end else if (req_q == REQ_INSERT) begin
            if (found_q) begin
              v_we         = 1'b1;
              out_status_d = RES_OK;
              out_slot_d   = idx_q;
            end else if (tomb_ok_q || empty_q) begin
              wr_addr      = tomb_ok_q ? tomb_q : idx_q;
              st_we        = 1'b1;
              st_wd        = SLOT_USED;
              kv_we        = 1'b1;
              v_we         = 1'b1;
              occ_d        = occ_q + CAP_W'(1);
              out_status_d = RES_OK;
              out_slot_d   = wr_addr;
            end else begin
              out_status_d = RES_FULL;
            end
          end else if (found_q) begin
            out_status_d = RES_OK;
            out_slot_d   = idx_q;
            if (req_q == REQ_GET) begin
              out_val_d = val_rd_q;
            end else begin
              st_we = 1'b1;
              st_wd = SLOT_TOMB;
              if (occ_q != '0) begin
                occ_d = occ_q - CAP_W'(1);
              end
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_value_out_o  = out_val_q;
  assign out_slot_index_o = out_slot_q;

`ifndef SYNTHESIS
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("Result appeared outside the finish step.");
  a_occ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CAP_W'(MAX_SLOTS))
    else $error("Occupancy count overflowed.");
  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> {1'b0, idx_q} < cap)
    else $error("Probe index beyond the table size.");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=>
      (state_q == ST_MOD || state_q == ST_CLEAR || state_q == ST_FINISH))
    else $error("Accepted transaction did not start work.");
`endif

endmodule

@@ verif/open_address_hash_table_tb.sv @@
// Self-checking testbench of the open-addressing hash table engine.
`timescale 1ns / 1ps

module open_address_hash_table_tb;
  import oaht_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [9:0]  slot;
  } lookup_result_t;

  class table_scoreboard;
    int unsigned size_reg = 1021;
    logic [1:0]  probe_reg = PROBE_LINEAR;
    logic [1:0]  state_mem [MAX_SLOTS];
    logic [63:0] key_mem [MAX_SLOTS];
    logic [31:0] val_mem [MAX_SLOTS];
    int unsigned fill_count = 0;
    lookup_result_t pending_q[$];
    int unsigned mismatches = 0;

    function new();
      foreach (state_mem[i]) state_mem[i] = SLOT_EMPTY;
    endfunction

    function int unsigned cap();
      if (size_reg < 2) return 2;
      if (size_reg > MAX_SLOTS) return MAX_SLOTS;
      return size_reg;
    endfunction

    function int unsigned slot_at(int unsigned home, int unsigned off, int unsigned c);
      longint unsigned o, stp;
      o = off;
      stp = 1 + home % (c - 1);
      if (probe_reg == PROBE_QUAD) return 32'((home + o * o) % c);
      if (probe_reg == PROBE_DOUBLE) return 32'((home + o * stp) % c);
      return 32'((home + o) % c);
    endfunction

    function void note_request(logic [1:0] req, logic [63:0] key, logic [9:0] home_in,
                               logic [31:0] val);
      lookup_result_t r;
      int unsigned c, home, idx, hit, tomb, empty;
      bit found, have_tomb, have_empty;
      c = cap();
      home = home_in % c;
      r = '0;
      r.status = RES_NOTFOUND;
      found = 0; have_tomb = 0; have_empty = 0; hit = 0; tomb = 0; empty = 0;
      if (req == REQ_CLEAR) begin
        foreach (state_mem[i]) state_mem[i] = SLOT_EMPTY;
        fill_count = 0;
        r.status = RES_OK;
        pending_q.push_back(r);
        return;
      end
      if (req == REQ_INSERT && fill_count >= c - 1) begin
        r.status = RES_FULL;
        pending_q.push_back(r);
        return;
      end
      for (int unsigned off = 0; off < c; off++) begin
        idx = slot_at(home, off, c);
        if (state_mem[idx] == SLOT_EMPTY) begin
          have_empty = 1; empty = idx;
          break;
        end
        if (state_mem[idx] == SLOT_TOMB) begin
          if (!have_tomb) begin
            have_tomb = 1; tomb = idx;
          end
        end else if (key_mem[idx] == key) begin
          found = 1; hit = idx;
          break;
        end
      end
      if (req == REQ_INSERT) begin
        if (found) begin
          val_mem[hit] = val;
          r.status = RES_OK; r.slot = 10'(hit);
        end else if (have_tomb || have_empty) begin
          idx = have_tomb ? tomb : empty;
          state_mem[idx] = SLOT_USED;
          key_mem[idx] = key;
          val_mem[idx] = val;
          fill_count++;
          r.status = RES_OK; r.slot = 10'(idx);
        end else begin
          r.status = RES_FULL;
        end
      end else if (found) begin
        r.status = RES_OK; r.slot = 10'(hit);
        if (req == REQ_GET) begin
          r.value_out = val_mem[hit];
        end else begin
          state_mem[hit] = SLOT_TOMB;
          if (fill_count > 0) fill_count--;
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t exp;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending_q.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d value %0d slot %0d, got %0d %0d %0d",
                   exp.status, $signed(exp.value_out), exp.slot,
                   got.status, $signed(got.value_out), got.slot);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 0, out_stall_i = 0;
  logic [1:0] in_req_type_i = '0;
  logic [63:0] in_key_i = '0;
  logic [9:0] in_home_index_i = '0;
  logic signed [31:0] in_value_i = '0;
  logic in_stall_o, out_valid_o;
  logic [1:0] out_status_o;
  logic signed [31:0] out_value_out_o;
  logic [9:0] out_slot_index_o;

  table_scoreboard sb = new();
  logic [63:0] key_pool [8];

  open_address_hash_table dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(cfg_reg_e idx, int unsigned data);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= CFG_W'(data);
    @(negedge clk_i);
    cfg_we_i <= 0;
    if (idx == REG_TABLE_SIZE) sb.size_reg = data;
    else sb.probe_reg = data[1:0];
  endtask

  task automatic send(logic [1:0] req, logic [63:0] key, logic [9:0] home,
                      logic [31:0] val);
    repeat (1 + gap_len()) @(negedge clk_i);
    in_valid_i <= 1; in_req_type_i <= req; in_key_i <= key;
    in_home_index_i <= home; in_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req, key, home, val);
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic random_phase(int unsigned n, int unsigned keyspan);
    logic [1:0] req;
    logic [63:0] k;
    for (int unsigned i = 0; i < n; i++) begin
      k = key_pool[$urandom_range(0, keyspan)];
      if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
      case ($urandom_range(0, 99)) inside
        [0:44]: req = REQ_INSERT;
        [45:74]: req = REQ_GET;
        [75:97]: req = REQ_REMOVE;
        default: req = REQ_CLEAR;
      endcase
      send(req, k,
           10'((k[9:0] ^ k[41:32]) % (sb.cap() + (($urandom_range(0, 19) == 0) ? 900 : 0))),
           $urandom);
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i)
      sb.check_result('{out_status_o, out_value_out_o, out_slot_index_o});
  end

  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 0;
    else if ($urandom_range(0, 3) == 0) out_stall_i <= ($urandom_range(0, 9) < 8);
    else out_stall_i <= ($urandom_range(0, 9) == 0);
  end

  initial begin
    int unsigned sizes [6] = '{2, 3, 7, 13, 1024, 0};
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1;
    // Directed: field extremes, every request type, full table, long chains.
    write_reg(REG_TABLE_SIZE, 5);
    send(REQ_GET, '0, 0, 0);
    send(REQ_INSERT, '0, 0, 32'h7fffffff);
    send(REQ_INSERT, '1, 10'h3ff, 32'h80000000);
    send(REQ_INSERT, '0, 0, 32'hffffffff);
    send(REQ_GET, '0, 0, 0);
    send(REQ_GET, '1, 10'h3ff, 0);
    send(REQ_INSERT, 64'h5, 1, 1);
    send(REQ_INSERT, 64'h6, 1, 2);
    send(REQ_INSERT, 64'h7, 1, 3);
    send(REQ_REMOVE, 64'h5, 1, 0);
    send(REQ_REMOVE, 64'h5, 1, 0);
    send(REQ_INSERT, 64'h8, 2, 4);
    send(REQ_GET, 64'h9, 3, 0);
    send(REQ_INSERT, 64'h6, 1, 9);
    send(REQ_CLEAR, '1, 10'h3ff, '1);
    drain();
    write_reg(REG_PROBE_KIND, PROBE_UNUSED);
    write_reg(REG_TABLE_SIZE, 1);
    send(REQ_INSERT, 64'h1, 3, 1);
    send(REQ_INSERT, 64'h2, 3, 1);
    send(REQ_REMOVE, 64'h1, 0, 0);
    send(REQ_GET, 64'h2, 1, 0);
    send(REQ_INSERT, 64'h3, 1, 1);
    drain();
    write_reg(REG_TABLE_SIZE, 2047);
    send(REQ_INSERT, 64'h3, 10'h3ff, 1);
    send(REQ_GET, 64'h3, 10'h3ff, 0);
    drain();
    for (int unsigned ph = 0; ph < 12; ph++) begin
      write_reg(REG_TABLE_SIZE, sizes[ph % 6] == 0 ? $urandom_range(2, 31) : sizes[ph % 6]);
      write_reg(REG_PROBE_KIND, ph % 4);
      random_phase(52, 7);
      drain();
    end
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
